// File: rtl/core/uvsg_pkg.sv
package uvsg_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_RING_COUNT    = 2'd0;
  localparam logic [1:0] REG_SEGMENT_COUNT = 2'd1;
  localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

  localparam logic [12:0] RING_COUNT_RST    = 13'd8;
  localparam logic [12:0] SEGMENT_COUNT_RST = 13'd16;
  localparam logic [15:0] SPHERE_RADIUS_RST = 16'd256;

  // Phase bits after the binary point of a turn
  localparam int PHASE_BITS = 32;
  // Texture coordinate width, Q0.16 plus the 1.0 bit
  localparam int TEX_BITS = 17;

  // CORDIC datapath: Q2.30 with headroom
  localparam int CW_BITS = 34;
  localparam logic signed [CW_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

// File: rtl/core/uvsg_div.sv
// Restoring divider, one quotient bit per stage: integer bit, then 32 fraction bits.
// Gives round(n * 2^32 / d) mod 2^32 and round(n * 2^TEX_FRAC / d).
module uvsg_div #(
  parameter int NW = 13,
  parameter int DW = 13,
  parameter int TEX_FRAC = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [NW-1:0]                   num,
  input  logic [DW-1:0]                   den,
  output logic [uvsg_pkg::PHASE_BITS-1:0] phase,
  output logic [uvsg_pkg::TEX_BITS-1:0]   tex
);

  localparam int RW = DW + 1;
  localparam int QW = uvsg_pkg::PHASE_BITS + 1;
  localparam int NS = QW;

  logic [RW-1:0]                 r_s [NS];
  logic [QW-1:0]                 q_s [NS];
  logic [uvsg_pkg::TEX_BITS-1:0] t_s [NS];

  logic [RW-1:0] den_x;
  logic [RW-1:0] half_up;

  assign den_x   = RW'(den);
  // remainder at or above this rounds the quotient up
  assign half_up = den_x - (den_x >> 1);

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [RW-1:0]                 rin;
    logic [RW-1:0]                 rn;
    logic                          ge;
    logic [QW-1:0]                 qn;
    logic [uvsg_pkg::TEX_BITS-1:0] tn;

    if (j == 0) begin : g_first
      assign rin = RW'(num);
      assign qn  = QW'(ge);
      assign tn  = '0;
    end else begin : g_next
      assign rin  = {r_s[j-1][RW-2:0], 1'b0};
      assign qn   = {q_s[j-1][QW-2:0], ge};
      if (j == TEX_FRAC + 1) begin : g_tap
        logic [TEX_FRAC+1:0] tsum;
        assign tsum = (TEX_FRAC+2)'(q_s[j-1][TEX_FRAC:0])
                    + (TEX_FRAC+2)'(r_s[j-1] >= half_up);
        assign tn = tsum[uvsg_pkg::TEX_BITS-1:0];
      end else begin : g_pass
        assign tn = t_s[j-1];
      end
    end

    assign ge = (rin >= den_x);
    assign rn = ge ? (rin - den_x) : rin;

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[j] <= rn;
        q_s[j] <= qn;
        t_s[j] <= tn;
      end
    end
  end

  logic [QW-1:0] psum;
  assign psum = q_s[NS-1] + QW'(r_s[NS-1] >= half_up);

  // round stage
  always_ff @(posedge clk) begin
    if (en) begin
      phase <= psum[uvsg_pkg::PHASE_BITS-1:0];
      tex   <= t_s[NS-1];
    end
  end

endmodule

// File: rtl/core/uvsg_cordic.sv
// Rotation-mode CORDIC on a phase in 2^-32 turn, one iteration per stage.
module uvsg_cordic #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [uvsg_pkg::PHASE_BITS-1:0] phase,
  output logic signed [31:0]              cos_q30,
  output logic signed [31:0]              sin_q30
);

  localparam int W = uvsg_pkg::CW_BITS;

  logic signed [W-1:0] x_s [TRIG_ITERATIONS];
  logic signed [W-1:0] y_s [TRIG_ITERATIONS];
  logic signed [W-1:0] z_s [TRIG_ITERATIONS];
  logic                f_s [TRIG_ITERATIONS];

  logic                z0;
  logic signed [W-1:0] z_red;
  logic                flip;
  logic                flip_in;
  logic [31:0]         p_red;

  // fold quadrants 1 and 2 onto 3 and 0 by a half turn
  assign flip_in = phase[31] ^ phase[30];
  assign p_red   = flip_in ? (phase ^ 32'h80000000) : phase;

  always_ff @(posedge clk) begin
    if (en) begin
      z_red <= W'(signed'(p_red));
      flip  <= flip_in;
    end
  end
  assign z0 = 1'b0;

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
    logic signed [W-1:0] xi, yi, zi;
    logic                fi;
    logic signed [W-1:0] at;

    if (i == 0) begin : g_first
      assign xi = uvsg_pkg::CORDIC_GAIN;
      assign yi = '0;
      assign zi = z_red;
      assign fi = flip | z0;
    end else begin : g_next
      assign xi = x_s[i-1];
      assign yi = y_s[i-1];
      assign zi = z_s[i-1];
      assign fi = f_s[i-1];
    end

    assign at = W'(signed'({1'b0, uvsg_pkg::ATAN_TURNS[i]}));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[W-1]) begin
          x_s[i] <= xi - (yi >>> i);
          y_s[i] <= yi + (xi >>> i);
          z_s[i] <= zi - at;
        end else begin
          x_s[i] <= xi + (yi >>> i);
          y_s[i] <= yi - (xi >>> i);
          z_s[i] <= zi + at;
        end
        f_s[i] <= fi;
      end
    end
  end

  logic signed [W-1:0] xo, yo;
  assign xo = f_s[TRIG_ITERATIONS-1] ? -x_s[TRIG_ITERATIONS-1] : x_s[TRIG_ITERATIONS-1];
  assign yo = f_s[TRIG_ITERATIONS-1] ? -y_s[TRIG_ITERATIONS-1] : y_s[TRIG_ITERATIONS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q30 <= signed'(xo[31:0]);
      sin_q30 <= signed'(yo[31:0]);
    end
  end

endmodule

// File: rtl/core/uvsg_scale.sv
// Direction products, radius scaling, rounding and saturation over four stages.
module uvsg_scale (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] cos_p,
  input  logic signed [31:0] sin_p,
  input  logic signed [31:0] cos_a,
  input  logic signed [31:0] sin_a,
  input  logic [15:0]        radius,
  output logic signed [16:0] pos [3],
  output logic signed [15:0] nrm [3]
);

  logic signed [63:0] prod [3];
  logic signed [31:0] dir  [3];
  logic signed [48:0] mpos [3];
  logic signed [16:0] nsh  [3];
  logic signed [16:0] rad_s;

  assign rad_s = signed'({1'b0, radius});

  // stage 1: sinP*cosA, cosP, sinP*sinA
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= sin_p * cos_a;
      prod[1] <= 64'(cos_p) <<< 30;
      prod[2] <= sin_p * sin_a;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [63:0] dsh;
    logic signed [31:0] nsum;
    logic signed [48:0] psh;

    // cosP passes unchanged: adding the half and flooring its shifted form is exact
    assign dsh  = (prod[k] + 64'sd536870912) >>> 30;
    assign nsum = (dir[k] + 32'sd16384) >>> 15;
    assign psh  = (mpos[k] + 49'sd536870912) >>> 30;

    always_ff @(posedge clk) begin
      if (en) begin
        dir[k]  <= signed'(dsh[31:0]);
        mpos[k] <= rad_s * dir[k];
        nsh[k]  <= signed'(nsum[16:0]);
        if (psh > 49'sd65535) begin
          pos[k] <= 17'sd65535;
        end else if (psh < -49'sd65535) begin
          pos[k] <= -17'sd65535;
        end else begin
          pos[k] <= signed'(psh[16:0]);
        end
        if (nsh[k] > 17'sd32767) begin
          nrm[k] <= 16'sd32767;
        end else if (nsh[k] < -17'sd32767) begin
          nrm[k] <= -16'sd32767;
        end else begin
          nrm[k] <= signed'(nsh[k][15:0]);
        end
      end
    end
  end

endmodule

// File: rtl/core/uv_sphere_vertex_gen_top.sv
// UV sphere vertex generator.
// Input channel (in_valid / in_stall): one word names a grid point by ring_index
// and segment_index. Output channel (out_valid / out_stall): one word per input
// word with position (Q8.8), unit normal (Q1.15) and texture coordinates (Q0.16).
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets
// ring_count, segment_count and sphere_radius; cfg_ready is always high. Write
// it only while no word is in flight.
// Throughput: one word per cycle while the output is not stalled. The word path
// runs through the two restoring dividers (33 quotient stages and a round stage
// each), the CORDIC reduce, iteration and output stages and the four-stage
// product/scale pipe.
// Reset clears all in-flight words and restores the register defaults
// (8 rings, 16 segments, radius 1.0).
// When the receiver stalls a valid output word, the whole pipe holds and
// in_stall rises; the output word stays stable until taken. Bubbles never
// stall the input.
module uv_sphere_vertex_gen_top #(
  parameter int COUNT_BITS      = 12,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [12:0]        ring_index,
  input  logic [12:0]        segment_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CW        = COUNT_BITS + 1;
  localparam int EW        = (CW > 13) ? CW : 13;
  localparam int DIV_LAT   = uvsg_pkg::PHASE_BITS + 2;
  localparam int CORD_LAT  = TRIG_ITERATIONS + 2;
  localparam int SCALE_LAT = 4;
  localparam int TAIL_LAT  = CORD_LAT + SCALE_LAT;
  localparam int LAT       = DIV_LAT + TAIL_LAT;
  localparam logic [EW-1:0] MAX_COUNT = EW'(1) << COUNT_BITS;

  logic [12:0] ring_count;
  logic [12:0] segment_count;
  logic [15:0] sphere_radius;
  logic        en;

  // whole pipe advances unless a finished word is blocked
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count    <= uvsg_pkg::RING_COUNT_RST;
      segment_count <= uvsg_pkg::SEGMENT_COUNT_RST;
      sphere_radius <= uvsg_pkg::SPHERE_RADIUS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        uvsg_pkg::REG_RING_COUNT:    ring_count    <= cfg_data[12:0];
        uvsg_pkg::REG_SEGMENT_COUNT: segment_count <= cfg_data[12:0];
        uvsg_pkg::REG_SPHERE_RADIUS: sphere_radius <= cfg_data;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // effective counts: zero acts as one, clip at 2^COUNT_BITS
  logic [EW-1:0] rings_e, segs_e, ring_e, seg_e;
  logic [CW-1:0] rings, segs, ring_sat, seg_sat;

  always_comb begin
    rings_e = EW'(ring_count);
    segs_e  = EW'(segment_count);
    if (rings_e == '0) begin
      rings_e = EW'(1);
    end else if (rings_e > MAX_COUNT) begin
      rings_e = MAX_COUNT;
    end
    if (segs_e == '0) begin
      segs_e = EW'(1);
    end else if (segs_e > MAX_COUNT) begin
      segs_e = MAX_COUNT;
    end
    ring_e = EW'(ring_index);
    seg_e  = EW'(segment_index);
    if (ring_e > rings_e) begin
      ring_e = rings_e;
    end
    if (seg_e > segs_e) begin
      seg_e = segs_e;
    end
  end

  assign rings    = rings_e[CW-1:0];
  assign segs     = segs_e[CW-1:0];
  assign ring_sat = ring_e[CW-1:0];
  assign seg_sat  = seg_e[CW-1:0];

  // polar: a half turn is ring * 2^32 / (2 * rings), rounding unchanged
  logic [uvsg_pkg::PHASE_BITS-1:0] pphase, aphase;
  logic [uvsg_pkg::TEX_BITS-1:0]   tv_div, tu_div;

  uvsg_div #(.NW(CW), .DW(CW + 1), .TEX_FRAC(17)) u_div_polar (
    .clk(clk), .en(en), .num(ring_sat), .den({rings, 1'b0}),
    .phase(pphase), .tex(tv_div)
  );

  uvsg_div #(.NW(CW), .DW(CW), .TEX_FRAC(16)) u_div_azim (
    .clk(clk), .en(en), .num(seg_sat), .den(segs),
    .phase(aphase), .tex(tu_div)
  );

  logic signed [31:0] cp, sp, ca, sa;

  uvsg_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic_polar (
    .clk(clk), .en(en), .phase(pphase), .cos_q30(cp), .sin_q30(sp)
  );

  uvsg_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic_azim (
    .clk(clk), .en(en), .phase(aphase), .cos_q30(ca), .sin_q30(sa)
  );

  logic signed [16:0] pos [3];
  logic signed [15:0] nrm [3];

  uvsg_scale u_scale (
    .clk(clk), .en(en), .cos_p(cp), .sin_p(sp), .cos_a(ca), .sin_a(sa),
    .radius(sphere_radius), .pos(pos), .nrm(nrm)
  );

  assign pos_x  = pos[0];
  assign pos_y  = pos[1];
  assign pos_z  = pos[2];
  assign norm_x = nrm[0];
  assign norm_y = nrm[1];
  assign norm_z = nrm[2];

  // texture words ride alongside the trig and scale stages
  logic [uvsg_pkg::TEX_BITS-1:0] tu_d [TAIL_LAT];
  logic [uvsg_pkg::TEX_BITS-1:0] tv_d [TAIL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      tu_d[0] <= tu_div;
      tv_d[0] <= tv_div;
      for (int i = 1; i < TAIL_LAT; i++) begin
        tu_d[i] <= tu_d[i-1];
        tv_d[i] <= tv_d[i-1];
      end
    end
  end

  assign tex_u = tu_d[TAIL_LAT-1];
  assign tex_v = tv_d[TAIL_LAT-1];

  // valid bits travel with the data
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

endmodule
